[rtl/nstr_pkg.sv]
// Shared types and constants for the nested scope timer recorder.
// No dependencies; nstr_ctrl and nested_scope_timer_recorder refer to it by scoped names.
package nstr_pkg;

    localparam logic [2:0] CMD_FRAME_BEGIN = 3'd0;
    localparam logic [2:0] CMD_SCOPE_BEGIN = 3'd1;
    localparam logic [2:0] CMD_SCOPE_END   = 3'd2;
    localparam logic [2:0] CMD_FRAME_END   = 3'd3;
    localparam logic [2:0] CMD_READ_ENTRY  = 3'd4;

    localparam logic REG_BUDGET_LIMIT = 1'b0;
    localparam logic REG_CHECK_ENABLE = 1'b1;

    localparam logic [63:0] BUDGET_RESET = 64'd16666666;

    typedef struct packed {
        logic [63:0] budget_limit_ns;
        logic        check_enable;
    } cfg_t;

endpackage

[rtl/nstr_ram.sv]
// Single-port-write, single-port-read synchronous memory with registered read data.
// No dependencies.
module nstr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/nstr_ctrl.sv]
// Request sequencer: reads the stack and entry memories, then writes them back
// and loads the result register. Depends on nstr_pkg and nstr_ram.
module nstr_ctrl #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_DEPTH   = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nstr_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         command,
    input  logic [63:0]        now_ns,
    input  logic [15:0]        scope_tag,
    input  logic [5:0]         close_level,
    input  logic               close_is_sentinel,
    input  logic [7:0]         read_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         given_level,
    output logic               begin_rejected,
    output logic               end_applied,
    output logic               over_budget,
    output logic               overflow_seen,
    output logic [8:0]         entries_used,
    output logic [15:0]        slot_tag,
    output logic [63:0]        slot_elapsed_ns,
    output logic [5:0]         slot_level,
    output logic [7:0]         slot_parent
);

    localparam int EAW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW  = $clog2(MAX_ENTRIES + 1);
    localparam int SAW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int DW  = $clog2(MAX_DEPTH + 1);
    localparam int MW  = 16 + 6 + EAW;
    localparam int SW  = EAW + 64;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic           state_reg, state_next;
    logic [2:0]     cmd_reg;
    logic [63:0]    now_reg;
    logic [15:0]    tag_reg;
    logic           hit_reg, hit_next;
    logic [CW-1:0]  used_reg, used_next;
    logic [DW-1:0]  depth_reg, depth_next;
    logic           ovf_reg, ovf_next;
    logic           out_valid_reg, out_valid_next;

    logic [5:0]     given_reg, given_next;
    logic           rej_reg, rej_next;
    logic           appl_reg, appl_next;
    logic           over_reg, over_next;
    logic [15:0]    stag_reg, stag_next;
    logic [63:0]    sel_reg, sel_next;
    logic [5:0]     slev_reg, slev_next;
    logic [7:0]     spar_reg, spar_next;

    logic           accept;
    logic           finish;

    logic           meta_we, elap_we, stk_we;
    logic [EAW-1:0] meta_waddr, elap_waddr, meta_raddr, elap_raddr;
    logic [SAW-1:0] stk_waddr, stk_raddr;
    logic [MW-1:0]  meta_wdata, meta_rdata;
    logic [63:0]    elap_wdata, elap_rdata;
    logic [SW-1:0]  stk_wdata, stk_rdata;
    logic [EAW-1:0] parent_idx;
    logic [31:0]    used_wide;
    logic [31:0]    parent_wide;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign finish   = (state_reg == S_EXEC) && (!out_valid_reg || !out_stall);

    // request decode at accept: hit flag and memory read addresses
    always_comb
    begin
        hit_next   = 1'b0;
        meta_raddr = EAW'(read_slot);
        elap_raddr = EAW'(read_slot);
        stk_raddr  = SAW'(close_level);
        case (command)
            nstr_pkg::CMD_SCOPE_BEGIN:
            begin
                hit_next  = (used_reg < CW'(MAX_ENTRIES)) && (depth_reg < DW'(MAX_DEPTH));
                stk_raddr = SAW'(depth_reg - 1'b1);
            end
            nstr_pkg::CMD_SCOPE_END:
            begin
                hit_next = !close_is_sentinel && (depth_reg != '0)
                           && ({1'b0, close_level} == 7'(depth_reg) - 7'd1);
            end
            nstr_pkg::CMD_FRAME_END:
            begin
                hit_next   = cfg.check_enable && (used_reg != '0);
                elap_raddr = '0;
            end
            nstr_pkg::CMD_READ_ENTRY:
            begin
                hit_next = (32'(read_slot) < 32'(used_reg))
                           && (32'(read_slot) < 32'(MAX_ENTRIES));
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    // execute: write back and form the result
    always_comb
    begin
        used_next  = used_reg;
        depth_next = depth_reg;
        ovf_next   = ovf_reg;
        meta_we    = 1'b0;
        elap_we    = 1'b0;
        stk_we     = 1'b0;
        parent_idx = (depth_reg != '0) ? stk_rdata[SW-1 -: EAW] : '0;
        meta_waddr = used_reg[EAW-1:0];
        meta_wdata = {tag_reg, 6'(depth_reg), parent_idx};
        elap_waddr = used_reg[EAW-1:0];
        elap_wdata = '0;
        stk_waddr  = SAW'(depth_reg);
        stk_wdata  = {used_reg[EAW-1:0], now_reg};
        given_next = '0;
        rej_next   = 1'b0;
        appl_next  = 1'b0;
        over_next  = 1'b0;
        stag_next  = '0;
        sel_next   = '0;
        slev_next  = '0;
        spar_next  = '0;
        parent_wide = 32'(meta_rdata[EAW-1:0]);
        case (cmd_reg)
            nstr_pkg::CMD_FRAME_BEGIN:
            begin
                used_next  = '0;
                depth_next = '0;
                ovf_next   = 1'b0;
            end
            nstr_pkg::CMD_SCOPE_BEGIN:
            begin
                if (hit_reg)
                begin
                    meta_we    = 1'b1;
                    elap_we    = 1'b1;
                    stk_we     = 1'b1;
                    used_next  = used_reg + 1'b1;
                    depth_next = depth_reg + 1'b1;
                    given_next = 6'(depth_reg);
                end
                else
                begin
                    ovf_next = 1'b1;
                    rej_next = 1'b1;
                end
            end
            nstr_pkg::CMD_SCOPE_END:
            begin
                if (hit_reg)
                begin
                    elap_we    = 1'b1;
                    elap_waddr = stk_rdata[SW-1 -: EAW];
                    elap_wdata = now_reg - stk_rdata[63:0];
                    depth_next = depth_reg - 1'b1;
                    appl_next  = 1'b1;
                end
            end
            nstr_pkg::CMD_FRAME_END:
            begin
                over_next = hit_reg && (elap_rdata > cfg.budget_limit_ns);
            end
            nstr_pkg::CMD_READ_ENTRY:
            begin
                if (hit_reg)
                begin
                    stag_next = meta_rdata[MW-1 -: 16];
                    slev_next = meta_rdata[EAW +: 6];
                    sel_next  = elap_rdata;
                    spar_next = parent_wide[7:0];
                end
            end
            default:
            begin
                used_next = used_reg;
            end
        endcase
        used_wide = 32'(used_next);
    end

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            state_next = S_EXEC;
        end
        else if (finish)
        begin
            state_next = S_IDLE;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            depth_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                used_reg  <= used_next;
                depth_reg <= depth_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            now_reg <= now_ns;
            tag_reg <= scope_tag;
            hit_reg <= hit_next;
        end
        if (finish)
        begin
            given_reg <= given_next;
            rej_reg   <= rej_next;
            appl_reg  <= appl_next;
            over_reg  <= over_next;
            stag_reg  <= stag_next;
            sel_reg   <= sel_next;
            slev_reg  <= slev_next;
            spar_reg  <= spar_next;
            entries_used  <= used_wide[8:0];
            overflow_seen <= ovf_next;
        end
    end

    nstr_ram #(.WIDTH(MW), .DEPTH(MAX_ENTRIES)) u_meta_ram (
        .clk   (clk),
        .we    (finish && meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .re    (accept),
        .raddr (meta_raddr),
        .rdata (meta_rdata)
    );

    nstr_ram #(.WIDTH(64), .DEPTH(MAX_ENTRIES)) u_elap_ram (
        .clk   (clk),
        .we    (finish && elap_we),
        .waddr (elap_waddr),
        .wdata (elap_wdata),
        .re    (accept),
        .raddr (elap_raddr),
        .rdata (elap_rdata)
    );

    nstr_ram #(.WIDTH(SW), .DEPTH(MAX_DEPTH)) u_stack_ram (
        .clk   (clk),
        .we    (finish && stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign out_valid       = out_valid_reg;
    assign given_level     = given_reg;
    assign begin_rejected  = rej_reg;
    assign end_applied     = appl_reg;
    assign over_budget     = over_reg;
    assign slot_tag        = stag_reg;
    assign slot_elapsed_ns = sel_reg;
    assign slot_level      = slev_reg;
    assign slot_parent     = spar_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(depth_reg) <= MAX_DEPTH)
        else $error("open depth beyond stack size");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(used_reg) <= MAX_ENTRIES)
        else $error("entry count beyond table size");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !out_valid_reg) |=> out_valid_reg)
        else $error("result not loaded after execute");

    a_end_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && cmd_reg == nstr_pkg::CMD_SCOPE_END && hit_reg)
        |=> depth_reg == $past(depth_reg) - 1'b1)
        else $error("scope end did not pop the stack");

    a_reject_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rej_reg) |-> overflow_seen)
        else $error("rejected begin without overflow flag");

endmodule

[rtl/nested_scope_timer_recorder.sv]
// A request is captured and its memories read at accept; the result registers load when
// the execute state finishes. No new request is taken until then: the memory read then
// write-back must finish, and a stalled result holds the sequencer in its execute state.
// Reset: asynchronous, active low; clears counts, depth, overflow, handshake state and
// the configuration registers to their defaults. Memories are not cleared.
module nested_scope_timer_recorder #(
    parameter int MAX_ENTRIES = 256,
    parameter int MAX_DEPTH   = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [63:0] now_ns,
    input  logic [15:0] scope_tag,
    input  logic [5:0]  close_level,
    input  logic        close_is_sentinel,
    input  logic [7:0]  read_slot,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [5:0]  given_level,
    output logic        begin_rejected,
    output logic        end_applied,
    output logic        over_budget,
    output logic        overflow_seen,
    output logic [8:0]  entries_used,
    output logic [15:0] slot_tag,
    output logic [63:0] slot_elapsed_ns,
    output logic [5:0]  slot_level,
    output logic [7:0]  slot_parent,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    nstr_pkg::cfg_t cfg_reg;
    logic           cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.budget_limit_ns <= nstr_pkg::BUDGET_RESET;
            cfg_reg.check_enable    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[3] == nstr_pkg::REG_BUDGET_LIMIT)
            begin
                cfg_reg.budget_limit_ns <= pwdata;
            end
            else
            begin
                cfg_reg.check_enable <= pwdata[0];
            end
        end
    end

    assign prdata = (paddr[3] == nstr_pkg::REG_CHECK_ENABLE)
                    ? {63'd0, cfg_reg.check_enable} : cfg_reg.budget_limit_ns;

    nstr_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_DEPTH   (MAX_DEPTH)
    ) u_ctrl (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .now_ns            (now_ns),
        .scope_tag         (scope_tag),
        .close_level       (close_level),
        .close_is_sentinel (close_is_sentinel),
        .read_slot         (read_slot),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .given_level       (given_level),
        .begin_rejected    (begin_rejected),
        .end_applied       (end_applied),
        .over_budget       (over_budget),
        .overflow_seen     (overflow_seen),
        .entries_used      (entries_used),
        .slot_tag          (slot_tag),
        .slot_elapsed_ns   (slot_elapsed_ns),
        .slot_level        (slot_level),
        .slot_parent       (slot_parent)
    );

endmodule
